FILE: sv/ccsa_pkg.sv
// Package for the calendar clock second advance: constants, stage types, month table.
`default_nettype none

package ccsa_pkg;

    // Field limits
    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;

    // Year / 25 by reciprocal: floor(y * 20972 / 2^19) is exact for any 14-bit y
    localparam int          DIV25_SHIFT = 19;
    localparam logic [14:0] DIV25_MUL   = 15'd20972;
    localparam int          PROD_W      = 29;

    // Stage 1: registered inputs, range check, reciprocal product
    typedef struct packed {
        logic [5:0]        sec;
        logic [5:0]        min;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [13:0]       year;
        logic              bad;
        logic              mod4_zero;
        logic              mod16_zero;
        logic [PROD_W-1:0] prod;
    } t_stage1;

    // Stage 2: leap resolved into a month length
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        bad;
        logic [4:0]  mlen;
    } t_stage2;

    // Stage 3: finished result
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        bad;
    } t_result;

    // Days in a month; codes outside 1..12 are flagged bad elsewhere
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: sv/calendar_clock_second_advance.sv
// Top level: pipelined one-second advance of a Gregorian date and time.
//
// Usage:
//   Drive the date and time on i_*_in and raise start for one cycle per item.
//   An item transfers at a rising edge with start high and busy low. busy is
//   always low: the pipeline takes a new item in every cycle.
//   Each result passes through the stage registers r_s1, r_s2 and r_s3 and is
//   shown on o_*_out with o_bad_input, for exactly one cycle marked by
//   o_valid, and is taken at the rising edge that ends that cycle. Results
//   leave in the order the items came in; the receiver cannot stall them.
//   Throughput: 1 item per cycle, set by the three equal register stages
//   (range check and year/25 product, leap and month length, day compare
//   and carry chain).
//   An input with any field out of range, or a day past the month's end,
//   comes back unchanged with o_bad_input set.
//   Reset (i_rst_n low, synchronous) clears the stage valid bits; items in
//   flight are dropped and no result is shown until new items arrive.
//   Year 9999 wraps to year 0; year 0 counts as a leap year.
`default_nettype none

module calendar_clock_second_advance
    import ccsa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [5:0]  i_second_in,
    input  wire  [5:0]  i_minute_in,
    input  wire  [4:0]  i_hour_in,
    input  wire  [4:0]  i_day_in,
    input  wire  [3:0]  i_month_in,
    input  wire  [13:0] i_year_in,
    output logic        o_valid,
    output logic [5:0]  o_second_out,
    output logic [5:0]  o_minute_out,
    output logic [4:0]  o_hour_out,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out,
    output logic        o_bad_input
);

    t_stage1 r_s1, n_s1;
    t_stage2 r_s2, n_s2;
    t_result r_s3, n_s3;
    logic    r_v1, r_v2, r_v3;

    logic [9:0]  q25;
    logic [14:0] q25_x25;
    logic        div25;
    logic        leap;
    logic        bad3;
    logic        sec_wrap, min_wrap, hour_wrap, month_end, year_end;

    // Pipeline never stalls
    assign busy = 1'b0;

    // Stage 1: range checks, year mod 4 / mod 16, year times reciprocal of 25
    always_comb begin
        n_s1.sec        = i_second_in;
        n_s1.min        = i_minute_in;
        n_s1.hour       = i_hour_in;
        n_s1.day        = i_day_in;
        n_s1.month      = i_month_in;
        n_s1.year       = i_year_in;
        n_s1.bad        = (i_second_in > SEC_MAX) || (i_minute_in > MIN_MAX) ||
                          (i_hour_in > HOUR_MAX) || (i_month_in == 4'd0) ||
                          (i_month_in > MONTH_MAX) || (i_year_in > YEAR_MAX) ||
                          (i_day_in == 5'd0);
        n_s1.mod4_zero  = (i_year_in[1:0] == 2'd0);
        n_s1.mod16_zero = (i_year_in[3:0] == 4'd0);
        n_s1.prod       = PROD_W'(i_year_in) * PROD_W'(DIV25_MUL);
    end

    // Stage 2: divisibility by 25, leap rule, month length
    always_comb begin
        q25     = r_s1.prod[PROD_W-1:DIV25_SHIFT];
        q25_x25 = {1'b0, q25, 4'd0} + {2'b0, q25, 3'd0} + {5'd0, q25};
        div25   = (q25_x25 == {1'b0, r_s1.year});
        // divisible by 4 and not by 100, or by 400
        leap    = r_s1.mod4_zero && (!div25 || r_s1.mod16_zero);
        n_s2.sec   = r_s1.sec;
        n_s2.min   = r_s1.min;
        n_s2.hour  = r_s1.hour;
        n_s2.day   = r_s1.day;
        n_s2.month = r_s1.month;
        n_s2.year  = r_s1.year;
        n_s2.bad   = r_s1.bad;
        n_s2.mlen  = month_length(r_s1.month, leap);
    end

    // Stage 3: day bound check and carry chain
    always_comb begin
        bad3      = r_s2.bad || (r_s2.day > r_s2.mlen);
        sec_wrap  = (r_s2.sec == SEC_MAX);
        min_wrap  = sec_wrap && (r_s2.min == MIN_MAX);
        hour_wrap = min_wrap && (r_s2.hour == HOUR_MAX);
        month_end = hour_wrap && (r_s2.day == r_s2.mlen);
        year_end  = month_end && (r_s2.month == MONTH_MAX);

        n_s3 = '{sec: r_s2.sec, min: r_s2.min, hour: r_s2.hour, day: r_s2.day,
                 month: r_s2.month, year: r_s2.year, bad: bad3};
        if (!bad3) begin
            n_s3.sec = sec_wrap ? 6'd0 : r_s2.sec + 6'd1;
            if (sec_wrap) begin
                n_s3.min = min_wrap ? 6'd0 : r_s2.min + 6'd1;
            end
            if (min_wrap) begin
                n_s3.hour = hour_wrap ? 5'd0 : r_s2.hour + 5'd1;
            end
            if (hour_wrap) begin
                n_s3.day = month_end ? 5'd1 : r_s2.day + 5'd1;
            end
            if (month_end) begin
                n_s3.month = year_end ? 4'd1 : r_s2.month + 4'd1;
            end
            if (year_end) begin
                n_s3.year = (r_s2.year == YEAR_MAX) ? 14'd0 : r_s2.year + 14'd1;
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payload registers
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
        r_s3 <= n_s3;
    end

    // Result ports
    assign o_valid      = r_v3;
    assign o_second_out = r_s3.sec;
    assign o_minute_out = r_s3.min;
    assign o_hour_out   = r_s3.hour;
    assign o_day_out    = r_s3.day;
    assign o_month_out  = r_s3.month;
    assign o_year_out   = r_s3.year;
    assign o_bad_input  = r_s3.bad;

    // A result is only shown for an earlier transfer with start high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("result without a matching transfer");

    // Good results stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bad_input) |-> (o_second_out <= SEC_MAX &&
        o_minute_out <= MIN_MAX && o_hour_out <= HOUR_MAX && o_day_out != 5'd0 &&
        o_month_out != 4'd0 && o_month_out <= MONTH_MAX && o_year_out <= YEAR_MAX))
        else $error("advanced date out of range");

    // Bad inputs pass through unchanged (second, day and year are checked)
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> (o_second_out == $past(i_second_in, 3) &&
        o_day_out == $past(i_day_in, 3) && o_year_out == $past(i_year_in, 3)))
        else $error("bad input not passed through");

    // No minute carry unless the second wrapped
    a_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bad_input && o_second_out != 6'd0) |->
        (o_minute_out == $past(i_minute_in, 3) && o_hour_out == $past(i_hour_in, 3)))
        else $error("spurious carry out of seconds");

endmodule

`default_nettype wire
